// File: rtl/apc_pkg.sv
// Package for the address pair cache: sizes, command codes and the structs
// passed along the cell chain. No dependencies.
package apc_pkg;

   localparam int ENTRIES = 8;
   localparam int IDX_W   = $clog2(ENTRIES);
   localparam int IP_W    = 32;
   localparam int MAC_W   = 48;
   localparam int SLOT_W  = 3;

   localparam logic CMD_LOOKUP = 1'b0;
   localparam logic CMD_PUT    = 1'b1;

   // search item walking the chain, one cell per cycle
   typedef struct packed {
      logic             active;
      logic             cmd;
      logic [IP_W-1:0]  key;
      logic [MAC_W-1:0] mac;
      logic             hit;
      logic [IDX_W-1:0] idx;
      logic [MAC_W-1:0] hit_mac;
   } probe_type;

   // insert broadcast from the chain tail
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] idx;
      logic [IP_W-1:0]  key;
      logic [MAC_W-1:0] mac;
   } write_type;

endpackage

// File: rtl/apc_cell.sv
// One cache entry of the address pair cache plus one stage of the search chain.
// Depends on apc_pkg.
module apc_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [apc_pkg::IDX_W-1:0] cell_idx,
   input  apc_pkg::probe_type    probe_in,
   input  apc_pkg::write_type    wr,
   output apc_pkg::probe_type    probe_out
);
   import apc_pkg::*;

   logic             valid_ff;
   logic [IP_W-1:0]  ip_ff;
   logic [MAC_W-1:0] mac_ff;
   probe_type        probe_ff;
   probe_type        probe_in_nxt;
   logic             match;
   logic             wr_sel;

   assign match  = probe_in.active && !probe_in.hit && valid_ff && (ip_ff == probe_in.key);
   assign wr_sel = wr.en && (wr.idx == cell_idx);

   always_comb begin
      probe_in_nxt = probe_in;
      if (match) begin
         probe_in_nxt.hit     = 1'b1;
         probe_in_nxt.idx     = cell_idx;
         probe_in_nxt.hit_mac = mac_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (wr_sel) begin
         valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_sel) begin
         ip_ff  <= wr.key;
         mac_ff <= wr.mac;
      end else if (match && probe_in.cmd == CMD_PUT) begin
         // refresh the pair in place
         mac_ff <= probe_in.mac;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff.active <= 1'b0;
      end else begin
         probe_ff <= probe_in_nxt;
      end
   end

   assign probe_out = probe_ff;

endmodule

// File: rtl/address_pair_cache_round_robin.sv
// Top level of the address pair cache with round-robin replacement.
// Depends on apc_pkg and apc_cell.
//
// Usage:
//   req_* channel carries one command item: req_command (lookup or put),
//   req_lookup_ip and req_new_mac. rsp_* channel returns one item per command:
//   rsp_found, rsp_mac_out and rsp_slot. An item moves on a channel at a clock
//   edge where valid is high and stall is low.
//   Each item walks a row of ENTRIES cells, one cell per cycle; the first valid
//   cell whose address matches captures the hit and, for a put, refreshes its
//   MAC in passing. A put that misses is written at the chain tail into the
//   slot named by the round-robin pointer, which then advances with wrap.
//   An accepted item passes the probe register of every cell and then the
//   result register before rsp_valid rises; the cell chain carries one item
//   at a time, so a new item is taken only once the previous result is registered.
//   While a result waits with rsp_stall high, req_stall stays high; the result
//   register holds its item until it is taken.
//   Reset (synchronous, active high) clears every valid bit, the pointer and
//   both channels; the cache is usable as soon as reset drops.
module address_pair_cache_round_robin (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_command,
   input  logic [apc_pkg::IP_W-1:0]  req_lookup_ip,
   input  logic [apc_pkg::MAC_W-1:0] req_new_mac,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_found,
   output logic [apc_pkg::MAC_W-1:0] rsp_mac_out,
   output logic [apc_pkg::SLOT_W-1:0] rsp_slot
);
   import apc_pkg::*;

   probe_type        chain [0:ENTRIES];
   probe_type        tail;
   write_type        wr;
   logic             busy_ff, busy_in;
   logic [IDX_W-1:0] ptr_ff, ptr_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_found_ff, rsp_found_in;
   logic [MAC_W-1:0] rsp_mac_ff, rsp_mac_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic             req_take;
   logic             rsp_take;
   logic             insert;

   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign req_stall = busy_ff || (rsp_valid_ff && rsp_stall);
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      chain[0]         = '0;
      chain[0].active  = req_take;
      chain[0].cmd     = req_command;
      chain[0].key     = req_lookup_ip;
      chain[0].mac     = req_new_mac;
   end

   for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
      apc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_idx  (IDX_W'(k)),
         .probe_in  (chain[k]),
         .wr        (wr),
         .probe_out (chain[k+1])
      );
   end

   assign tail   = chain[ENTRIES];
   assign insert = tail.active && tail.cmd == CMD_PUT && !tail.hit;

   always_comb begin
      wr.en  = insert;
      wr.idx = ptr_ff;
      wr.key = tail.key;
      wr.mac = tail.mac;
   end

   always_comb begin
      ptr_in = ptr_ff;
      if (insert) begin
         ptr_in = (ptr_ff == IDX_W'(ENTRIES - 1)) ? '0 : ptr_ff + 1'b1;
      end
   end

   always_comb begin
      busy_in = busy_ff;
      if (req_take) begin
         busy_in = 1'b1;
      end else if (tail.active) begin
         busy_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      rsp_mac_in   = rsp_mac_ff;
      rsp_slot_in  = rsp_slot_ff;
      if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
      // output is empty whenever an item reaches the tail
      if (tail.active) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = tail.hit;
         rsp_mac_in   = (tail.hit && tail.cmd == CMD_LOOKUP) ? tail.hit_mac : '0;
         if (tail.hit) begin
            rsp_slot_in = SLOT_W'(tail.idx);
         end else if (tail.cmd == CMD_PUT) begin
            rsp_slot_in = SLOT_W'(ptr_ff);
         end else begin
            rsp_slot_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_found_ff <= rsp_found_in;
      rsp_mac_ff   <= rsp_mac_in;
      rsp_slot_ff  <= rsp_slot_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_found   = rsp_found_ff;
   assign rsp_mac_out = rsp_mac_ff;
   assign rsp_slot    = rsp_slot_ff;

endmodule
